// ===== hw/rtl/qau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Command codes and fixed constants of the inverse square root iteration.
// ----------------------------------------------------------------------------
package qau_pkg;

  typedef enum logic [2:0] {
    CMD_MUL  = 3'd0,
    CMD_DIFF = 3'd1,
    CMD_LDIV = 3'd2,
    CMD_ROT  = 3'd3,
    CMD_IROT = 3'd4,
    CMD_NORM = 3'd5
  } cmd_t;

  localparam int          YFRAC = 30;
  localparam logic [31:0] Y_ONE = 32'h4000_0000;
  localparam logic [33:0] Y_THREE = 34'h0_C000_0000;

endpackage
`default_nettype wire

// ===== hw/rtl/quaternion_arithmetic_unit.sv =====
// Throughput: one item per cycle while the result is not stalled; the datapath is
// fully pipelined, and the Newton iteration takes three register stages per step.
// A full output register holds the whole datapath until it is taken.
// Reset empties the queue and clears all valid flags; no data is cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Fixed-point quaternion products, rotation and normalization.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit #(
  parameter int DATA_WIDTH  = 16,
  parameter int FRAC_BITS   = 14,
  parameter int RSQRT_STEPS = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic [2:0]                   command,
  input  wire logic signed [DATA_WIDTH-1:0] a_w,
  input  wire logic signed [DATA_WIDTH-1:0] a_x,
  input  wire logic signed [DATA_WIDTH-1:0] a_y,
  input  wire logic signed [DATA_WIDTH-1:0] a_z,
  input  wire logic signed [DATA_WIDTH-1:0] b_w,
  input  wire logic signed [DATA_WIDTH-1:0] b_x,
  input  wire logic signed [DATA_WIDTH-1:0] b_y,
  input  wire logic signed [DATA_WIDTH-1:0] b_z,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic signed [DATA_WIDTH-1:0]      r_w,
  output logic signed [DATA_WIDTH-1:0]      r_x,
  output logic signed [DATA_WIDTH-1:0]      r_y,
  output logic signed [DATA_WIDTH-1:0]      r_z,
  output logic                              saturated,
  output logic                              zero_norm
);
  localparam int QW = 3 + 8 * (DATA_WIDTH + 1);

  logic          push;
  logic          full;
  logic [QW-1:0] push_data;
  logic          pop;
  logic          empty;
  logic [QW-1:0] head;

  qau_front #(.DW(DATA_WIDTH), .QW(QW)) u_front (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .push(push), .full(full), .push_data(push_data)
  );

  qau_fifo #(.WIDTH(QW), .DEPTH(4)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  qau_back #(.DW(DATA_WIDTH), .F(FRAC_BITS), .STEPS(RSQRT_STEPS), .QW(QW)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .pop(pop),
    .result_valid(result_valid), .result_stall(result_stall),
    .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
    .saturated(saturated), .zero_norm(zero_norm)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/qau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit front end
// Accepts items, applies the conjugations that each command asks for and
// hands the decoded operands to the queue.
// ----------------------------------------------------------------------------
module qau_front #(
  parameter int DW = 16,
  parameter int QW = 3 + 8 * (DW + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic [2:0]           command,
  input  wire logic signed [DW-1:0] a_w,
  input  wire logic signed [DW-1:0] a_x,
  input  wire logic signed [DW-1:0] a_y,
  input  wire logic signed [DW-1:0] a_z,
  input  wire logic signed [DW-1:0] b_w,
  input  wire logic signed [DW-1:0] b_x,
  input  wire logic signed [DW-1:0] b_y,
  input  wire logic signed [DW-1:0] b_z,
  output logic                      push,
  input  wire logic                 full,
  output logic [QW-1:0]             push_data
);
  import qau_pkg::*;

  localparam int AW = DW + 1;

  logic          held;
  logic [QW-1:0] data;
  logic [QW-1:0] data_next;
  logic          conj_a;
  logic          conj_b;
  logic signed [AW-1:0] ax, ay, az, bx, by, bz;

  always_comb begin
    conj_a = cmd_t'(command) == CMD_LDIV;
    conj_b = cmd_t'(command) == CMD_DIFF;
    ax = conj_a ? -AW'(a_x) : AW'(a_x);
    ay = conj_a ? -AW'(a_y) : AW'(a_y);
    az = conj_a ? -AW'(a_z) : AW'(a_z);
    bx = conj_b ? -AW'(b_x) : AW'(b_x);
    by = conj_b ? -AW'(b_y) : AW'(b_y);
    bz = conj_b ? -AW'(b_z) : AW'(b_z);
    data_next = {command, AW'(a_w), ax, ay, az, AW'(b_w), bx, by, bz};
  end

  assign item_stall = held && full;
  assign push       = held;
  assign push_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!item_stall) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qau_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit queue
// A short first-in first-out queue between the front end and the datapath.
// ----------------------------------------------------------------------------
module qau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      head
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == (PW + 1)'(DEPTH);
  assign empty   = count == '0;
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qau_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit datapath
// Pipelined products, rotation, inverse square root iteration and final
// rounding, with the output register at its end.
// ----------------------------------------------------------------------------
module qau_back #(
  parameter int DW    = 16,
  parameter int F     = 14,
  parameter int STEPS = 3,
  parameter int QW    = 3 + 8 * (DW + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  wire logic [QW-1:0] head,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [DW-1:0]      r_w,
  output logic [DW-1:0]      r_x,
  output logic [DW-1:0]      r_y,
  output logic [DW-1:0]      r_z,
  output logic               saturated,
  output logic               zero_norm
);
  import qau_pkg::*;

  localparam int AW  = DW + 1;
  localparam int PW  = 2 * AW;
  localparam int SW  = PW + 2;
  localparam int SNW = 2 * DW + 3;
  localparam int EW  = $clog2(SNW);
  localparam int NPW = DW + 34;
  localparam int MW  = (SW > NPW) ? SW : NPW;
  localparam int NS  = 3 * STEPS + 2;

  typedef struct packed {
    cmd_t                 cmd;
    logic [3:0][DW-1:0]   a;
    logic [EW-1:0]        h;
    logic                 zn;
    logic [3:0][DW-1:0]   r;
    logic                 sat;
  } side_t;

  function automatic logic [DW:0] clip_d(input logic signed [MW-1:0] v);
    logic lo_ok;
    logic hi_ok;
    lo_ok = &v[MW-1:DW-1];
    hi_ok = ~|v[MW-1:DW-1];
    if (lo_ok || hi_ok) begin
      return {1'b0, v[DW-1:0]};
    end else if (v[MW-1]) begin
      return {2'b11, {(DW-1){1'b0}}};
    end else begin
      return {2'b10, {(DW-1){1'b1}}};
    end
  endfunction

  function automatic logic [AW:0] clip_t(input logic signed [SW-1:0] v);
    logic fits;
    fits = (&v[SW-1:DW]) || (~|v[SW-1:DW]);
    if (fits && (v[DW:0] != {1'b1, {DW{1'b0}}})) begin
      return {1'b0, v[DW:0]};
    end else if (v[SW-1]) begin
      return {2'b11, {(DW-1){1'b0}}, 1'b1};
    end else begin
      return {2'b10, {DW{1'b1}}};
    end
  endfunction

  logic en;
  assign en  = !(result_valid && result_stall);
  assign pop = en && !empty;

  // Stage 1: products.
  logic                 v1;
  cmd_t                 cmd1;
  logic signed [AW-1:0] qa [4];
  logic signed [AW-1:0] qb [4];
  logic signed [PW-1:0] mp1 [4][4];
  logic signed [PW-1:0] sq1 [4];
  logic [DW-1:0]        a1 [4];
  logic [DW-1:0]        b1 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qa[i] = $signed(head[QW-4-i*AW -: AW]);
      qb[i] = $signed(head[QW-4-(4+i)*AW -: AW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= cmd_t'(head[QW-1 -: 3]);
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          mp1[i][j] <= qa[i] * qb[j];
        end
        sq1[i] <= qa[i] * qa[i];
        a1[i]  <= qa[i][DW-1:0];
        b1[i]  <= qb[i][DW-1:0];
      end
    end
  end

  // Stage 2: quaternion products, rotation intermediate, squared norm.
  logic                 v2;
  cmd_t                 cmd2;
  logic [DW-1:0]        a2 [4];
  logic [DW-1:0]        vv2 [3];
  logic [DW-1:0]        rq2 [4];
  logic                 rqsat2;
  logic signed [AW-1:0] t2 [3];
  logic                 tsat2;
  logic [SNW-1:0]       s2;
  logic signed [SW-1:0] qs [4];
  logic signed [SW-1:0] ts [3];
  logic [DW:0]          qc [4];
  logic [AW:0]          tc [3];
  logic [SNW-1:0]       s_next;
  logic signed [SW-1:0] half_f;
  logic signed [SW-1:0] half_f1;

  assign half_f  = SW'(1) <<< (F - 1);
  assign half_f1 = SW'(1) <<< (F - 2);

  always_comb begin
    qs[0] = SW'(mp1[0][0]) - SW'(mp1[1][1]) - SW'(mp1[2][2]) - SW'(mp1[3][3]);
    qs[1] = SW'(mp1[0][1]) + SW'(mp1[1][0]) + SW'(mp1[2][3]) - SW'(mp1[3][2]);
    qs[2] = SW'(mp1[0][2]) - SW'(mp1[1][3]) + SW'(mp1[2][0]) + SW'(mp1[3][1]);
    qs[3] = SW'(mp1[0][3]) + SW'(mp1[1][2]) - SW'(mp1[2][1]) + SW'(mp1[3][0]);
    for (int i = 0; i < 4; i++) begin
      qc[i] = clip_d(MW'((qs[i] + half_f) >>> F));
    end
    for (int k = 0; k < 3; k++) begin
      ts[k] = SW'(mp1[(k+1)%3+1][(k+2)%3+1]) - SW'(mp1[(k+2)%3+1][(k+1)%3+1]);
      if (cmd1 == CMD_IROT) begin
        ts[k] = ts[k] - SW'(mp1[0][k+1]);
      end else begin
        ts[k] = ts[k] + SW'(mp1[0][k+1]);
      end
      tc[k] = clip_t((ts[k] + half_f) >>> F);
    end
    s_next = SNW'(unsigned'(sq1[0])) + SNW'(unsigned'(sq1[1]))
           + SNW'(unsigned'(sq1[2])) + SNW'(unsigned'(sq1[3]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2   <= cmd1;
      rqsat2 <= qc[0][DW] | qc[1][DW] | qc[2][DW] | qc[3][DW];
      tsat2  <= tc[0][AW] | tc[1][AW] | tc[2][AW];
      s2     <= s_next;
      for (int i = 0; i < 4; i++) begin
        a2[i]  <= a1[i];
        rq2[i] <= qc[i][DW-1:0];
      end
      for (int k = 0; k < 3; k++) begin
        vv2[k] <= b1[k+1];
        t2[k]  <= $signed(tc[k][AW-1:0]);
      end
    end
  end

  // Stage 3: second rotation products, leading one of the norm.
  logic                 v3;
  cmd_t                 cmd3;
  logic [DW-1:0]        a3 [4];
  logic [DW-1:0]        vv3 [3];
  logic [DW-1:0]        rq3 [4];
  logic                 rqsat3;
  logic                 tsat3;
  logic [SNW-1:0]       s3;
  logic [EW-1:0]        h3;
  logic signed [PW-1:0] rp3 [3][2];
  logic [EW-1:0]        e_next;

  always_comb begin
    e_next = '0;
    for (int i = 0; i < SNW; i++) begin
      if (s2[i]) begin
        e_next = EW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd3   <= cmd2;
      rqsat3 <= rqsat2;
      tsat3  <= tsat2;
      s3     <= s2;
      h3     <= {e_next[EW-1:1], 1'b0};
      for (int i = 0; i < 4; i++) begin
        a3[i]  <= a2[i];
        rq3[i] <= rq2[i];
      end
      for (int k = 0; k < 3; k++) begin
        vv3[k]    <= vv2[k];
        rp3[k][0] <= $signed(a2[(k+1)%3+1]) * t2[(k+2)%3];
        rp3[k][1] <= $signed(a2[(k+2)%3+1]) * t2[(k+1)%3];
      end
    end
  end

  // Stage 4: rotation result, start value of the iteration, command select.
  side_t                side [NS];
  logic                 vs [NS];
  logic [31:0]          ny [STEPS+1];
  logic [31:0]          nx [STEPS+1];
  logic [DW:0]          rc [3];
  logic [SNW+31:0]      sx;
  logic [31:0]          x_next;
  side_t                side_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rc[k] = clip_d(MW'(((SW'(rp3[k][0]) - SW'(rp3[k][1]) + half_f1) >>> (F - 1))
                         + SW'($signed(vv3[k]))));
    end
    sx = {32'b0, s3};
    if (int'(h3) >= YFRAC) begin
      sx = sx >> (int'(h3) - YFRAC);
    end else begin
      sx = sx << (YFRAC - int'(h3));
    end
    x_next = sx[31:0];
    side_next.cmd = cmd3;
    side_next.h   = h3;
    side_next.zn  = s3 == '0;
    for (int i = 0; i < 4; i++) begin
      side_next.a[i] = a3[i];
    end
    case (cmd3)
      CMD_MUL, CMD_DIFF, CMD_LDIV: begin
        for (int i = 0; i < 4; i++) begin
          side_next.r[i] = rq3[i];
        end
        side_next.sat = rqsat3;
      end
      CMD_ROT, CMD_IROT: begin
        side_next.r[0] = '0;
        for (int k = 0; k < 3; k++) begin
          side_next.r[k+1] = rc[k][DW-1:0];
        end
        side_next.sat = tsat3 | rc[0][DW] | rc[1][DW] | rc[2][DW];
      end
      default: begin
        side_next.r   = '0;
        side_next.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_next;
      nx[0]   <= x_next;
      ny[0]   <= Y_ONE - {3'b0, x_next[31:3]};
      for (int j = 1; j < NS; j++) begin
        side[j] <= side[j-1];
      end
    end
  end

  // Newton steps of the inverse square root, three stages each.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [31:0] ay, ay2, ax, by, bt, bx;
    logic [33:0] pr;

    assign pr = 34'((64'(ax) * 64'(ay2)) >> YFRAC);

    always_ff @(posedge clk) begin
      if (en) begin
        ay    <= ny[k];
        ax    <= nx[k];
        ay2   <= 32'((64'(ny[k]) * 64'(ny[k])) >> YFRAC);
        by    <= ay;
        bx    <= ax;
        bt    <= (pr >= Y_THREE) ? 32'd0 : 32'(Y_THREE - pr);
        ny[k+1] <= 32'((64'(by) * 64'(bt)) >> (YFRAC + 1));
        nx[k+1] <= bx;
      end
    end
  end

  // Final scaling of the normalized components.
  logic signed [DW+32:0] np [4];
  logic [6:0]            sh;
  logic signed [NPW-1:0] rnd;
  logic [DW:0]           nc [4];

  always_ff @(posedge clk) begin
    if (en) begin
      sh <= 7'(int'(side[NS-2].h >> 1) + YFRAC - F);
      for (int i = 0; i < 4; i++) begin
        np[i] <= $signed(side[NS-2].a[i]) * $signed({1'b0, ny[STEPS]});
      end
    end
  end

  always_comb begin
    rnd = (sh == '0) ? '0 : (NPW'(1) <<< (sh - 7'd1));
    for (int i = 0; i < 4; i++) begin
      nc[i] = clip_d(MW'((NPW'(np[i]) + rnd) >>> sh));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int j = 0; j < NS; j++) begin
        vs[j] <= 1'b0;
      end
      result_valid <= 1'b0;
    end else if (en) begin
      v1    <= pop;
      v2    <= v1;
      v3    <= v2;
      vs[0] <= v3;
      for (int j = 1; j < NS; j++) begin
        vs[j] <= vs[j-1];
      end
      result_valid <= vs[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side[NS-1].cmd == CMD_NORM) begin
        r_w       <= nc[0][DW-1:0];
        r_x       <= nc[1][DW-1:0];
        r_y       <= nc[2][DW-1:0];
        r_z       <= nc[3][DW-1:0];
        saturated <= nc[0][DW] | nc[1][DW] | nc[2][DW] | nc[3][DW];
        zero_norm <= side[NS-1].zn;
      end else begin
        r_w       <= side[NS-1].r[0];
        r_x       <= side[NS-1].r[1];
        r_y       <= side[NS-1].r[2];
        r_z       <= side[NS-1].r[3];
        saturated <= side[NS-1].sat;
        zero_norm <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_quaternion_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Drives directed and random commands through the valid/stall handshake,
// predicts every result in fixed point and checks each transfer field by field.
// ----------------------------------------------------------------------------
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int         FRAC = 14;
  localparam longint     DMAX = 32767;
  localparam longint     DMIN = -32768;
  localparam longint     TLIM = 65535;
  localparam int         CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              drain;
    logic [2:0]        cmd;
    logic signed [15:0] aw, ax, ay, az, bw, bx, by, bz;
  } quat_item_t;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic               sat, zn;
  } quat_result_t;

  logic clk, rst;
  logic item_valid, item_stall, result_valid, result_stall;
  logic [2:0] command;
  logic signed [15:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
  logic signed [15:0] r_w, r_x, r_y, r_z;
  logic saturated, zero_norm;

  quat_item_t   pending_items[$];
  quat_result_t expected_results[$];
  logic         took_item;
  logic         failed;
  int           cycles;
  int           burst_left, gap_left, stall_mode, stall_left;

  quaternion_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .command(command),
    .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .result_valid(result_valid), .result_stall(result_stall),
    .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
    .saturated(saturated), .zero_norm(zero_norm)
  );

  function automatic longint round_half_up(longint sum, int s);
    return (sum + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, inout logic sat);
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic quat_result_t predict_result(quat_item_t it);
    quat_result_t res;
    longint a[4], b[4], r[4], t[3];
    logic sat, zn;
    longint unsigned s, x, y, y2, pr, tt;
    int e, h, sh, i, j, k;
    longint sgn;
    a[0] = it.aw; a[1] = it.ax; a[2] = it.ay; a[3] = it.az;
    b[0] = it.bw; b[1] = it.bx; b[2] = it.by; b[3] = it.bz;
    r = '{0, 0, 0, 0};
    sat = 1'b0;
    zn = 1'b0;
    case (it.cmd)
      CMD_MUL, CMD_DIFF, CMD_LDIV: begin
        if (it.cmd == CMD_DIFF) for (i = 1; i < 4; i++) b[i] = -b[i];
        if (it.cmd == CMD_LDIV) for (i = 1; i < 4; i++) a[i] = -a[i];
        r[0] = clamp(round_half_up(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], FRAC),
                     DMIN, DMAX, sat);
        r[1] = clamp(round_half_up(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], FRAC),
                     DMIN, DMAX, sat);
        r[2] = clamp(round_half_up(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1], FRAC),
                     DMIN, DMAX, sat);
        r[3] = clamp(round_half_up(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0], FRAC),
                     DMIN, DMAX, sat);
      end
      CMD_ROT, CMD_IROT: begin
        sgn = (it.cmd == CMD_ROT) ? 1 : -1;
        for (k = 0; k < 3; k++) begin
          i = (k + 1) % 3;
          j = (k + 2) % 3;
          t[k] = clamp(round_half_up(a[i+1]*b[j+1] - a[j+1]*b[i+1] + sgn*a[0]*b[k+1], FRAC),
                       -TLIM, TLIM, sat);
        end
        for (k = 0; k < 3; k++) begin
          i = (k + 1) % 3;
          j = (k + 2) % 3;
          r[k+1] = clamp(b[k+1] + round_half_up(a[i+1]*t[j] - a[j+1]*t[i], FRAC - 1),
                         DMIN, DMAX, sat);
        end
      end
      CMD_NORM: begin
        s = 0;
        for (i = 0; i < 4; i++) s += longint'(a[i] * a[i]);
        if (s == 0) begin
          zn = 1'b1;
        end else begin
          e = 63;
          while (e > 0 && s[e] == 1'b0) e--;
          h = e & ~1;
          x = (h >= 30) ? (s >> (h - 30)) : (s << (30 - h));
          y = (64'd1 << 30) - (x >> 3);
          for (k = 0; k < 3; k++) begin
            y2 = (y * y) >> 30;
            pr = (x * y2) >> 30;
            tt = (pr >= 3 * (64'd1 << 30)) ? 0 : 3 * (64'd1 << 30) - pr;
            y = (y * tt) >> 31;
          end
          sh = 30 + h / 2 - FRAC;
          for (i = 0; i < 4; i++)
            r[i] = clamp(round_half_up(a[i] * longint'(y), sh), DMIN, DMAX, sat);
        end
      end
      default: ;
    endcase
    res.w = 16'(r[0]); res.x = 16'(r[1]); res.y = 16'(r[2]); res.z = 16'(r[3]);
    res.sat = sat;
    res.zn = zn;
    return res;
  endfunction

  function automatic logic signed [15:0] pick_value(int spread);
    case (spread)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 32768) - 16384);
      default: return 16'($urandom_range(0, 512) - 256);
    endcase
  endfunction

  function automatic quat_item_t make_item(logic [2:0] cmd, int spread);
    quat_item_t it;
    it.drain = 1'b0;
    it.cmd = cmd;
    it.aw = pick_value(spread); it.ax = pick_value(spread);
    it.ay = pick_value(spread); it.az = pick_value(spread);
    it.bw = pick_value(spread); it.bx = pick_value(spread);
    it.by = pick_value(spread); it.bz = pick_value(spread);
    return it;
  endfunction

  function automatic quat_item_t fill_item(logic [2:0] cmd, logic signed [15:0] av,
                                           logic signed [15:0] bv);
    quat_item_t it;
    it.drain = 1'b0;
    it.cmd = cmd;
    it.aw = av; it.ax = av; it.ay = av; it.az = av;
    it.bw = bv; it.bx = bv; it.by = bv; it.bz = bv;
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    quat_item_t it;
    logic [2:0] cmds[8];
    int n;
    cmds = '{CMD_MUL, CMD_DIFF, CMD_LDIV, CMD_ROT, CMD_IROT, CMD_NORM, CMD_SPARE6, CMD_SPARE7};
    for (n = 0; n < 6; n++) begin
      pending_items.push_back(fill_item(cmds[n], 16'sh7fff, 16'sh8000));
      pending_items.push_back(fill_item(cmds[n], 16'sh8000, 16'sh8000));
    end
    pending_items.push_back(fill_item(CMD_NORM, 16'sh0000, 16'sh1234));
    pending_items.push_back(fill_item(CMD_NORM, 16'sh0001, 16'sh0000));
    it = fill_item(CMD_NORM, 16'sh0000, 16'sh0000);
    it.ax = 16'sh4000;
    pending_items.push_back(it);
    it = fill_item(CMD_ROT, 16'sh0000, 16'sh4000);
    it.aw = 16'sh4000;
    pending_items.push_back(it);
    it.cmd = CMD_IROT;
    pending_items.push_back(it);
    pending_items.push_back(fill_item(CMD_MUL, 16'sh0000, 16'sh7fff));
    pending_items.push_back(fill_item(CMD_SPARE6, 16'sh7fff, 16'sh7fff));
    pending_items.push_back(fill_item(CMD_SPARE7, 16'sh8000, 16'sh8000));
    for (n = 0; n < 1200; n++) begin
      if ($urandom_range(0, 99) < 2) it = make_item(cmds[$urandom_range(6, 7)], 0);
      else it = make_item(cmds[$urandom_range(0, 5)], $urandom_range(0, 2));
      it.drain = (n == 600);
      pending_items.push_back(it);
    end
  end

  always @(negedge clk) begin
    quat_item_t it;
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!item_valid || took_item) begin
        if (gap_left > 0) begin
          item_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && expected_results.size() > 0)) begin
          it = pending_items.pop_front();
          item_valid <= 1'b1;
          command <= it.cmd;
          a_w <= it.aw; a_x <= it.ax; a_y <= it.ay; a_z <= it.az;
          b_w <= it.bw; b_x <= it.bx; b_y <= it.by; b_z <= it.bz;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(10, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= (cycles % 7) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    quat_item_t it;
    quat_result_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_arithmetic_unit: mismatch");
      $finish;
    end else if (!rst) begin
      if (result_valid && !result_stall) begin
        got.w = r_w; got.x = r_x; got.y = r_y; got.z = r_z;
        got.sat = saturated;
        got.zn = zero_norm;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, got);
          failed <= 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (got.w !== want.w) $display("%0t: r_w expected %0d actual %0d", $time, want.w, got.w);
          if (got.x !== want.x) $display("%0t: r_x expected %0d actual %0d", $time, want.x, got.x);
          if (got.y !== want.y) $display("%0t: r_y expected %0d actual %0d", $time, want.y, got.y);
          if (got.z !== want.z) $display("%0t: r_z expected %0d actual %0d", $time, want.z, got.z);
          if (got.sat !== want.sat)
            $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
          if (got.zn !== want.zn)
            $display("%0t: zero_norm expected %0b actual %0b", $time, want.zn, got.zn);
          if (got !== want) failed <= 1'b1;
        end
      end
      took_item <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        it.drain = 1'b0;
        it.cmd = command;
        it.aw = a_w; it.ax = a_x; it.ay = a_y; it.az = a_z;
        it.bw = b_w; it.bx = b_x; it.by = b_y; it.bz = b_z;
        expected_results.push_back(predict_result(it));
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    result_stall = 1'b0;
    command = CMD_MUL;
    {a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z} = '0;
    took_item = 1'b0;
    failed = 1'b0;
    cycles = 0;
    stall_mode = 0;
    stall_left = 0;
    burst_left = 0;
    gap_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (pending_items.size() == 0 && !item_valid && expected_results.size() == 0);
    repeat (40) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("quaternion_arithmetic_unit: match");
    end else begin
      $display("quaternion_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule
